>>> sv/ccsr_pkg.sv
// Shared sizes, result codes and control structs of the COO to CSR converter.
// No dependencies; every other file but ccsr_ram imports this package.
package ccsr_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_NNZ  = 4096;

  localparam int ROW_W  = 11;                       // row and column fields
  localparam int VAL_W  = 64;
  localparam int RSA_W  = $clog2(MAX_ROWS + 1);     // row start address
  localparam int CUR_A_W = $clog2(MAX_ROWS);        // cursor address
  localparam int NA_W   = $clog2(MAX_NNZ);          // entry address
  localparam int CNT_W  = $clog2(MAX_NNZ + 1);      // entry count
  localparam int POS_W  = 14;                       // emit position
  localparam int PTR_W  = 13;

  localparam int ARR_W  = ROW_W + ROW_W + 2 * VAL_W;
  localparam int SRT_W  = ROW_W + 2 * VAL_W;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_PTR   = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic CFG_ROW_COUNT  = 1'b0;
  localparam logic CFG_INDEX_BASE = 1'b1;

  typedef struct packed {
    logic accept;
    logic emitting;
    logic exec;
    logic conv_init;
    logic clr_wr;
    logic cnt_rd;
    logic cnt_rd2;
    logic cnt_wr;
    logic pfx_rd;
    logic pfx_wr;
    logic sc_rd;
    logic sc_cur;
    logic sc_wr;
    logic finish;
    logic emit_clear;
    logic idx_clr;
    logic idx_inc;
  } ccsr_cmd_t;

  typedef struct packed {
    logic pend_op;
    logic pend_last;
    logic pend_end;
    logic rng_last;
    logic arr_last;
    logic arr_empty;
    logic row_ok;
  } ccsr_sts_t;

endpackage

>>> sv/ccsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ccsr_ctrl.sv
// Controller of the COO to CSR converter: item sequencing and conversion passes.
// Depends on ccsr_pkg; drives ccsr_datapath through command and status structs.
module ccsr_ctrl
  import ccsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ccsr_sts_t sts,
  output ccsr_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_CNT_RD  = 4'd3;
  localparam logic [3:0] S_CNT_RD2 = 4'd4;
  localparam logic [3:0] S_CNT_WR  = 4'd5;
  localparam logic [3:0] S_PFX_RD  = 4'd6;
  localparam logic [3:0] S_PFX_WR  = 4'd7;
  localparam logic [3:0] S_SC_RD   = 4'd8;
  localparam logic [3:0] S_SC_CUR  = 4'd9;
  localparam logic [3:0] S_SC_WR   = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    emit_nxt     = emit_r;
    cmd          = '0;
    cmd.emitting = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.pend_op == OP_LOAD && !emit_r && sts.pend_last) begin
          cmd.conv_init = 1'b1;
          state_nxt     = S_CLR;
        end else if (sts.pend_op == OP_EMIT && emit_r && sts.pend_end) begin
          cmd.emit_clear = 1'b1;
          emit_nxt       = 1'b0;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.rng_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.arr_empty ? S_PFX_RD : S_CNT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CNT_RD2;
      end
      S_CNT_RD2: begin
        if (sts.row_ok) begin
          cmd.cnt_rd2 = 1'b1;
          state_nxt   = S_CNT_WR;
        end else if (sts.arr_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PFX_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CNT_RD;
        end
      end
      S_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        if (sts.arr_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PFX_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CNT_RD;
        end
      end
      S_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        if (sts.rng_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.arr_empty ? S_FIN : S_SC_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_PFX_RD;
        end
      end
      S_SC_RD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = S_SC_CUR;
      end
      S_SC_CUR: begin
        if (sts.row_ok) begin
          cmd.sc_cur = 1'b1;
          state_nxt  = S_SC_WR;
        end else if (sts.arr_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SC_RD;
        end
      end
      S_SC_WR: begin
        cmd.sc_wr = 1'b1;
        if (sts.arr_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SC_RD;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        emit_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/ccsr_datapath.sv
// Datapath of the COO to CSR converter: registers, counters, memories, result.
// Depends on ccsr_pkg and ccsr_ram; commanded by ccsr_ctrl.
module ccsr_datapath
  import ccsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ccsr_cmd_t        cmd,
  output ccsr_sts_t        sts,
  input  logic             in_operation,
  input  logic [ROW_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value_re,
  input  logic [VAL_W-1:0] in_value_im,
  input  logic             in_last_entry,
  input  logic             cfg_wr,
  input  logic             cfg_index,
  input  logic [ROW_W-1:0] cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_status,
  output logic [PTR_W-1:0] out_row_pointer,
  output logic [ROW_W-1:0] out_col_index,
  output logic [VAL_W-1:0] out_value_re,
  output logic [VAL_W-1:0] out_value_im,
  output logic             out_last_output
);

  logic [ROW_W-1:0] cfg_rows_r, lat_rows_r;
  logic             cfg_base_r, lat_base_r;
  logic [CNT_W-1:0] cnt_r, total_r, idx_r;
  logic [POS_W-1:0] p_r;
  logic             pend_op_r, pend_last_r, pend_ptr_r, pend_end_r;
  logic [1:0]       pend_status_r;

  logic             valid_r;
  logic [1:0]       kind_r, status_r;
  logic [PTR_W-1:0] rptr_r;
  logic [ROW_W-1:0] col_r;
  logic [VAL_W-1:0] re_r, im_r;
  logic             last_r;

  logic [ROW_W-1:0] eff_rows, rel_row, arr_row;
  logic             load_range, load_full, load_ok;
  logic [POS_W-1:0] emit_total, lat_ext, e_pos;
  logic             is_ptr;

  logic [ARR_W-1:0] arr_q;
  logic [PTR_W-1:0] rs_q, cur_q;
  logic [SRT_W-1:0] srt_q;

  logic             arr_we, arr_re, rs_we, rs_re, cur_we, cur_re;
  logic [RSA_W-1:0] rs_waddr, rs_raddr;
  logic [PTR_W-1:0] rs_wdata, cur_wdata;
  logic [CUR_A_W-1:0] cur_waddr;
  logic             srt_re;

  always_comb begin
    if (cfg_rows_r == '0) begin
      eff_rows = ROW_W'(1);
    end else if (cfg_rows_r > ROW_W'(MAX_ROWS)) begin
      eff_rows = ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = cfg_rows_r;
    end
  end

  assign rel_row    = in_row_index - ROW_W'(cfg_base_r);
  assign load_range = (in_row_index < ROW_W'(cfg_base_r)) || (rel_row >= eff_rows);
  assign load_full  = (cnt_r >= CNT_W'(MAX_NNZ));
  assign load_ok    = !load_range && !load_full;

  assign lat_ext    = POS_W'(lat_rows_r);
  assign emit_total = lat_ext + POS_W'(1) + POS_W'(cnt_r);
  assign is_ptr     = (p_r <= lat_ext);
  assign e_pos      = p_r - lat_ext - POS_W'(1);

  assign arr_row = arr_q[ARR_W-1 -: ROW_W];

  assign sts.pend_op   = pend_op_r;
  assign sts.pend_last = pend_last_r;
  assign sts.pend_end  = pend_end_r;
  assign sts.rng_last  = (idx_r == CNT_W'(lat_rows_r));
  assign sts.arr_last  = (idx_r == cnt_r - CNT_W'(1));
  assign sts.arr_empty = (cnt_r == '0);
  assign sts.row_ok    = (arr_row < lat_rows_r);

  // arrival store
  assign arr_we = cmd.accept && in_operation == OP_LOAD && !cmd.emitting && load_ok;
  assign arr_re = cmd.cnt_rd || cmd.sc_rd;

  ccsr_ram #(.WIDTH(ARR_W), .DEPTH(MAX_NNZ)) u_arr (
    .clk   (clk),
    .we    (arr_we),
    .waddr (cnt_r[NA_W-1:0]),
    .wdata ({rel_row, in_col_index, in_value_re, in_value_im}),
    .re    (arr_re),
    .raddr (idx_r[NA_W-1:0]),
    .rdata (arr_q)
  );

  // row starts, used as counts before the prefix pass
  assign rs_we    = cmd.clr_wr || cmd.cnt_wr || cmd.pfx_wr;
  assign rs_waddr = cmd.cnt_wr ? RSA_W'(arr_row) : idx_r[RSA_W-1:0];
  always_comb begin
    if (cmd.clr_wr) begin
      rs_wdata = '0;
    end else if (cmd.cnt_wr) begin
      rs_wdata = rs_q + PTR_W'(1);
    end else begin
      rs_wdata = PTR_W'(total_r);
    end
  end
  assign rs_re = (cmd.accept && in_operation == OP_EMIT && cmd.emitting && is_ptr)
                 || cmd.cnt_rd2 || cmd.pfx_rd;
  always_comb begin
    if (cmd.cnt_rd2) begin
      rs_raddr = RSA_W'(arr_row);
    end else if (cmd.pfx_rd) begin
      rs_raddr = idx_r[RSA_W-1:0];
    end else begin
      rs_raddr = p_r[RSA_W-1:0];
    end
  end

  ccsr_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_rs (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_q)
  );

  // per-row scatter cursors
  assign cur_we    = (cmd.pfx_wr && idx_r < CNT_W'(lat_rows_r)) || cmd.sc_wr;
  assign cur_waddr = cmd.sc_wr ? arr_row[CUR_A_W-1:0] : idx_r[CUR_A_W-1:0];
  assign cur_wdata = cmd.sc_wr ? cur_q + PTR_W'(1) : PTR_W'(total_r);
  assign cur_re    = cmd.sc_cur;

  ccsr_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS)) u_cur (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (arr_row[CUR_A_W-1:0]),
    .rdata (cur_q)
  );

  // sorted store
  assign srt_re = cmd.accept && in_operation == OP_EMIT && cmd.emitting && !is_ptr;

  ccsr_ram #(.WIDTH(SRT_W), .DEPTH(MAX_NNZ)) u_srt (
    .clk   (clk),
    .we    (cmd.sc_wr),
    .waddr (cur_q[NA_W-1:0]),
    .wdata (arr_q[SRT_W-1:0]),
    .re    (srt_re),
    .raddr (e_pos[NA_W-1:0]),
    .rdata (srt_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= ROW_W'(MAX_ROWS);
      cfg_base_r <= 1'b0;
      lat_rows_r <= ROW_W'(1);
      lat_base_r <= 1'b0;
      cnt_r      <= '0;
      p_r        <= '0;
      idx_r      <= '0;
      total_r    <= '0;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cfg_wr) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          cfg_rows_r <= cfg_data;
        end else begin
          cfg_base_r <= cfg_data[0];
        end
      end
      if (arr_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.conv_init) begin
        lat_rows_r <= eff_rows;
        lat_base_r <= cfg_base_r;
        total_r    <= '0;
        idx_r      <= '0;
      end else if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.pfx_wr) begin
        total_r <= total_r + CNT_W'(rs_q);
      end
      if (cmd.finish) begin
        cnt_r <= total_r;
        p_r   <= '0;
      end
      if (cmd.emit_clear) begin
        cnt_r <= '0;
        p_r   <= '0;
      end else if (cmd.exec && pend_op_r == OP_EMIT && cmd.emitting) begin
        p_r <= p_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_op_r   <= in_operation;
      pend_last_r <= in_last_entry;
      pend_ptr_r  <= is_ptr;
      pend_end_r  <= (p_r + POS_W'(1) == emit_total);
      if (load_range) begin
        pend_status_r <= ST_RANGE;
      end else if (load_full) begin
        pend_status_r <= ST_FULL;
      end else begin
        pend_status_r <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kind_r   <= KIND_NONE;
      status_r <= ST_OK;
      rptr_r   <= '0;
      col_r    <= '0;
      re_r     <= '0;
      im_r     <= '0;
      last_r   <= 1'b0;
      if (pend_op_r == OP_LOAD) begin
        if (!cmd.emitting) begin
          kind_r   <= KIND_ACK;
          status_r <= pend_status_r;
        end
      end else if (cmd.emitting) begin
        if (pend_ptr_r) begin
          kind_r <= KIND_PTR;
          rptr_r <= rs_q + PTR_W'(lat_base_r);
        end else begin
          kind_r <= KIND_ENTRY;
          col_r  <= srt_q[SRT_W-1 -: ROW_W];
          re_r   <= srt_q[2*VAL_W-1:VAL_W];
          im_r   <= srt_q[VAL_W-1:0];
          last_r <= pend_end_r;
        end
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_status      = status_r;
  assign out_row_pointer = rptr_r;
  assign out_col_index   = col_r;
  assign out_value_re    = re_r;
  assign out_value_im    = im_r;
  assign out_last_output = last_r;

endmodule

>>> sv/coo_to_csr_converter_unit.sv
// Top level of the COO to CSR converter: controller plus datapath.
// Depends on ccsr_pkg, ccsr_ctrl, ccsr_datapath and ccsr_ram.
//
//   channel   handshake               payload
//   input     start, busy             in_operation .. in_last_entry
//   result    out_valid (one cycle)   out_kind .. out_last_output
//   config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A load or emit item is accepted, then the memory read or write settles in the
// execute state and the result strobes in the cycle after. The entry marked last
// adds a conversion walk (a clearing pass over the row starts, a counting pass
// over the stored entries, a prefix pass and a scatter pass into the sorted
// store), during which busy stays high and no new item is accepted.
// Reset is synchronous; no clearing pass is needed. Results cannot be stalled.
module coo_to_csr_converter_unit
  import ccsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_operation,
  input  logic [ROW_W-1:0] in_row_index,
  input  logic [ROW_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value_re,
  input  logic [VAL_W-1:0] in_value_im,
  input  logic             in_last_entry,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_status,
  output logic [PTR_W-1:0] out_row_pointer,
  output logic [ROW_W-1:0] out_col_index,
  output logic [VAL_W-1:0] out_value_re,
  output logic [VAL_W-1:0] out_value_im,
  output logic             out_last_output,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [ROW_W-1:0] cfg_data
);

  ccsr_cmd_t cmd;
  ccsr_sts_t sts;

  assign cfg_ready = 1'b1;

  ccsr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ccsr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value_re     (in_value_re),
    .in_value_im     (in_value_im),
    .in_last_entry   (in_last_entry),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_row_pointer (out_row_pointer),
    .out_col_index   (out_col_index),
    .out_value_re    (out_value_re),
    .out_value_im    (out_value_im),
    .out_last_output (out_last_output)
  );

endmodule

>>> sv/ccsr_checker.sv
// Port-level checks of the COO to CSR converter, bound to the top level.
// Depends on ccsr_pkg and coo_to_csr_converter_unit.
module ccsr_checker
  import ccsr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [1:0]       out_kind,
  input logic [1:0]       out_status,
  input logic             out_last_output
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid ##1 out_valid)
    else $error("accepted item gave no result two cycles later");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_status_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ACK |-> out_status == ST_OK)
    else $error("status set on a non-acknowledge result");

  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_output |-> out_kind == KIND_ENTRY)
    else $error("last mark on a result that is not a sorted entry");

endmodule

bind coo_to_csr_converter_unit ccsr_checker u_ccsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_kind        (out_kind),
  .out_status      (out_status),
  .out_last_output (out_last_output)
);
